// File: rtl/packed_slot_bitmap_unit_top_defines.svh
// Assertion macros shared by the RTL of the packed slot bitmap unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PACKED_SLOT_BITMAP_UNIT_TOP_DEFINES_SVH
`define PACKED_SLOT_BITMAP_UNIT_TOP_DEFINES_SVH

// Check an implication on every rising clock edge outside reset.
`define PSBU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define PSBU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/psbu_pkg.sv
// Shared types and constants of the packed slot bitmap unit.
// Depends on nothing; used by packed_slot_bitmap_unit_top, psbu_result_checker and testbench.
package psbu_pkg;

   // word and section layout
   localparam int unsigned WORD_W     = 64;
   localparam int unsigned SECT_W     = 16;
   localparam int unsigned NUM_SECT   = 4;
   localparam int unsigned IDX_W      = 2;
   localparam int unsigned MAP_W      = 10;
   localparam int unsigned TAG_W      = 6;
   localparam int unsigned VAL_W      = 16;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned OP_W       = 4;

   localparam logic [VAL_W-1:0] TAG_MAX = 16'd63;
   localparam logic [VAL_W-1:0] MAP_MAX = 16'h03FF;
   localparam logic [CNT_W-1:0] SLOTS   = 4'd10;

   // reciprocal of ten: floor(v * 52429 / 2^19) == v / 10 for any 16-bit v
   localparam logic [VAL_W-1:0] RECIP10     = 16'd52429;
   localparam int unsigned      RECIP_SHIFT = 19;
   localparam int unsigned      QUOT_W      = 2 * VAL_W - RECIP_SHIFT;

   // stream packing
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 80;

   typedef enum logic [OP_W-1:0] {
      OP_GET_SECT = 4'd0,
      OP_GET_TAG  = 4'd1,
      OP_GET_MAP  = 4'd2,
      OP_COUNT    = 4'd3,
      OP_SET_SECT = 4'd4,
      OP_SET_TAG  = 4'd5,
      OP_SET_MAP  = 4'd6,
      OP_FILL     = 4'd7,
      OP_CLEAR    = 4'd8,
      OP_TOGGLE   = 4'd9,
      OP_ROTL     = 4'd10,
      OP_ROTR     = 4'd11
   } op_type;

endpackage

// File: rtl/packed_slot_bitmap_unit_top.sv
// Top level of the packed slot bitmap unit: a three-stage operation pipeline.
// Depends on psbu_pkg and packed_slot_bitmap_unit_top_defines.svh.
//
// The unit takes one transaction per cycle unless the result side stalls, and
// returns one result per transaction, in order, via the output register. Stage
// one latches the transaction, extracts the selected
// section and multiplies the operand by the reciprocal of ten; stage two
// finishes the modulo-ten rotate amount and computes the new section and the
// query value; stage three merges the section back into the word and holds
// the result. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Operation codes 12 to 15 return the word unchanged with a zero query.
`include "packed_slot_bitmap_unit_top_defines.svh"

module packed_slot_bitmap_unit_top (
   input  logic                             clock,
   input  logic                             reset,
   // request: tuser = operation[3:0]
   // tdata = aisle_in[63:0], sect_sel[65:64], operand_value[81:66], zero[87:82]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [psbu_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [psbu_pkg::OP_W-1:0]        req_tuser,
   // response: tdata = aisle_out[63:0], query_value[79:64]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [psbu_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int unsigned WW = psbu_pkg::WORD_W;
   localparam int unsigned SW = psbu_pkg::SECT_W;
   localparam int unsigned MW = psbu_pkg::MAP_W;
   localparam int unsigned VW = psbu_pkg::VAL_W;
   localparam int unsigned CW = psbu_pkg::CNT_W;

   // set the cnt lowest clear bits of m
   function automatic logic [MW-1:0] fill_low(input logic [MW-1:0] m,
                                              input logic [CW-1:0] cnt);
      logic [MW-1:0] r;
      logic [CW-1:0] rank;
      r = m;
      for (int i = 0; i < MW; i++) begin
         rank = '0;
         for (int j = 0; j < i; j++) begin
            rank = rank + CW'(!m[j]);
         end
         if (!m[i] && (rank < cnt)) begin
            r[i] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] pop_map(input logic [MW-1:0] m);
      logic [CW-1:0] c;
      c = '0;
      for (int i = 0; i < MW; i++) begin
         c = c + CW'(m[i]);
      end
      return c;
   endfunction

   logic advance;

   // stage one registers
   logic                        s1_valid_ff, s1_valid_in;
   logic [psbu_pkg::OP_W-1:0]   s1_op_ff, s1_op_in;
   logic [WW-1:0]               s1_word_ff, s1_word_in;
   logic [psbu_pkg::IDX_W-1:0]  s1_idx_ff, s1_idx_in;
   logic [VW-1:0]               s1_val_ff, s1_val_in;
   logic [SW-1:0]               s1_sect_ff, s1_sect_in;
   logic [2*VW-1:0]             s1_prod_ff, s1_prod_in;

   // stage two registers
   logic                        s2_valid_ff, s2_valid_in;
   logic [psbu_pkg::OP_W-1:0]   s2_op_ff, s2_op_in;
   logic [WW-1:0]               s2_word_ff, s2_word_in;
   logic [psbu_pkg::IDX_W-1:0]  s2_idx_ff, s2_idx_in;
   logic [SW-1:0]               s2_sect_ff, s2_sect_in;
   logic                        s2_wr_ff, s2_wr_in;
   logic [VW-1:0]               s2_query_ff, s2_query_in;

   // output registers
   logic                        out_valid_ff, out_valid_in;
   logic [WW-1:0]               out_word_ff, out_word_in;
   logic [VW-1:0]               out_query_ff, out_query_in;

   // stage two working signals
   logic [MW-1:0]               s2_map;
   logic [psbu_pkg::TAG_W-1:0]  s2_tag;
   logic [psbu_pkg::QUOT_W-1:0] s2_quot;
   logic [VW-1:0]               s2_quot10;
   logic [CW-1:0]               s2_rem;
   logic [CW-1:0]               s2_rot;
   logic [CW-1:0]               s2_fcnt;
   logic [2*MW-1:0]             s2_dbl;
   logic [MW-1:0]               s2_rmap;

   // advance the whole pipe when the output register can take a new result
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_query_ff, out_word_ff};

   // stage one: latch the transaction, pick the section, start the modulo
   always_comb begin
      s1_valid_in = req_tvalid;
      s1_op_in    = req_tuser;
      s1_word_in  = req_tdata[WW-1:0];
      s1_idx_in   = req_tdata[WW +: psbu_pkg::IDX_W];
      s1_val_in   = req_tdata[WW + psbu_pkg::IDX_W +: VW];
      s1_sect_in  = s1_word_in[s1_idx_in * SW +: SW];
      s1_prod_in  = s1_val_in * psbu_pkg::RECIP10;
   end

   // stage two: finish the rotate amount and compute the new section
   always_comb begin
      s2_map    = s1_sect_ff[MW-1:0];
      s2_tag    = s1_sect_ff[SW-1:MW];
      s2_quot   = s1_prod_ff[2*VW-1:psbu_pkg::RECIP_SHIFT];
      s2_quot10 = VW'({s2_quot, 3'b000}) + VW'({s2_quot, 1'b0});
      s2_rem    = CW'(s1_val_ff - s2_quot10);
      s2_rot    = s2_rem;
      if (psbu_pkg::op_type'(s1_op_ff) == psbu_pkg::OP_ROTR && s2_rem != '0) begin
         s2_rot = psbu_pkg::SLOTS - s2_rem;
      end
      s2_dbl  = {s2_map, s2_map} << s2_rot;
      s2_rmap = s2_dbl[2*MW-1:MW];
      s2_fcnt = (s1_val_ff > VW'(psbu_pkg::SLOTS)) ? psbu_pkg::SLOTS : CW'(s1_val_ff);

      s2_valid_in = s1_valid_ff;
      s2_op_in    = s1_op_ff;
      s2_word_in  = s1_word_ff;
      s2_idx_in   = s1_idx_ff;
      s2_sect_in  = s1_sect_ff;
      s2_wr_in    = 1'b0;
      s2_query_in = '0;
      case (s1_op_ff)
         psbu_pkg::OP_GET_SECT: s2_query_in = s1_sect_ff;
         psbu_pkg::OP_GET_TAG:  s2_query_in = VW'(s2_tag);
         psbu_pkg::OP_GET_MAP:  s2_query_in = VW'(s2_map);
         psbu_pkg::OP_COUNT:    s2_query_in = VW'(pop_map(s2_map));
         psbu_pkg::OP_SET_SECT: begin
            s2_sect_in = s1_val_ff;
            s2_wr_in   = 1'b1;
         end
         psbu_pkg::OP_SET_TAG: begin
            s2_sect_in = {s1_val_ff[psbu_pkg::TAG_W-1:0], s2_map};
            s2_wr_in   = (s1_val_ff <= psbu_pkg::TAG_MAX);
         end
         psbu_pkg::OP_SET_MAP: begin
            s2_sect_in = {s2_tag, s1_val_ff[MW-1:0]};
            s2_wr_in   = (s1_val_ff <= psbu_pkg::MAP_MAX);
         end
         psbu_pkg::OP_FILL: begin
            s2_sect_in = {s2_tag, fill_low(s2_map, s2_fcnt)};
            s2_wr_in   = 1'b1;
         end
         psbu_pkg::OP_CLEAR: begin
            s2_sect_in = {s2_tag, ~fill_low(~s2_map, s2_fcnt)};
            s2_wr_in   = 1'b1;
         end
         psbu_pkg::OP_TOGGLE: begin
            s2_sect_in = {s2_tag, s2_map ^ (MW'(1) << s1_val_ff[CW-1:0])};
            s2_wr_in   = (s1_val_ff < VW'(psbu_pkg::SLOTS));
         end
         psbu_pkg::OP_ROTL, psbu_pkg::OP_ROTR: begin
            s2_sect_in = {s2_tag, s2_rmap};
            s2_wr_in   = 1'b1;
         end
         default: begin
            s2_wr_in = 1'b0;
         end
      endcase
   end

   // stage three: merge the section back into the word
   always_comb begin
      out_valid_in = s2_valid_ff;
      out_query_in = s2_query_ff;
      out_word_in  = s2_word_ff;
      for (int k = 0; k < psbu_pkg::NUM_SECT; k++) begin
         if (s2_wr_ff && s2_idx_ff == psbu_pkg::IDX_W'(k)) begin
            out_word_in[k*SW +: SW] = s2_sect_ff;
         end
      end
   end

   // clear valid bits under reset, advance all stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff     <= s1_op_in;
         s1_word_ff   <= s1_word_in;
         s1_idx_ff    <= s1_idx_in;
         s1_val_ff    <= s1_val_in;
         s1_sect_ff   <= s1_sect_in;
         s1_prod_ff   <= s1_prod_in;
         s2_op_ff     <= s2_op_in;
         s2_word_ff   <= s2_word_in;
         s2_idx_ff    <= s2_idx_in;
         s2_sect_ff   <= s2_sect_in;
         s2_wr_ff     <= s2_wr_in;
         s2_query_ff  <= s2_query_in;
         out_word_ff  <= out_word_in;
         out_query_ff <= out_query_in;
      end
   end

   // an item held in stage one under a stall is not dropped
   `PSBU_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff,
      "stage one item lost during stall")

   // an item leaving stage two lands in the output register
   `PSBU_ASSERT_NEXT(a_s2_to_out, clock, reset, s2_valid_ff && advance, rsp_tvalid,
      "stage two item not delivered")

   // update operations never carry a query value
   `PSBU_ASSERT_IMPL(a_query_zero, clock, reset,
      s2_valid_ff && s2_op_ff >= psbu_pkg::OP_SET_SECT, s2_query_ff == '0,
      "nonzero query on update operation")

   // query operations never modify the word
   `PSBU_ASSERT_IMPL(a_query_no_wr, clock, reset,
      s2_valid_ff && s2_op_ff < psbu_pkg::OP_SET_SECT, !s2_wr_ff,
      "query operation writes the word")

endmodule

// File: tb/psbu_result_checker.sv
// Result checker for the packed slot bitmap unit: watches both stream channels,
// predicts each result from the accepted request and compares field by field.
// Depends on psbu_pkg for widths, limits and operation codes.
module psbu_result_checker
   import psbu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // aisle_in, sect_sel, operand_value, zero
   input  logic [OP_W-1:0]        req_tuser,   // operation
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // aisle_out, query_value
   output int                     error_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [WORD_W-1:0] aisle;
      logic [VAL_W-1:0]  query;
   } slot_result_type;

   slot_result_type pending_results[$];
   int              fault_total = 0;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Compute the word and query value that one operation produces.
   function automatic slot_result_type apply_slot_op(input logic [OP_W-1:0]   op,
                                                     input logic [WORD_W-1:0] word,
                                                     input logic [IDX_W-1:0]  idx,
                                                     input logic [VAL_W-1:0]  val);
      logic [SECT_W-1:0] sect;
      logic [MAP_W-1:0]  map;
      logic [MAP_W-1:0]  nmap;
      logic [TAG_W-1:0]  tag;
      int unsigned       moved;
      int unsigned       rot;
      int unsigned       occupied;
      slot_result_type   r;
      sect     = word[idx*SECT_W +: SECT_W];
      map      = sect[MAP_W-1:0];
      tag      = sect[SECT_W-1:MAP_W];
      nmap     = map;
      moved    = 0;
      occupied = 0;
      r.aisle  = word;
      r.query  = '0;
      case (op)
         OP_GET_SECT: r.query = sect;
         OP_GET_TAG:  r.query = VAL_W'(tag);
         OP_GET_MAP:  r.query = VAL_W'(map);
         OP_COUNT: begin
            for (int i = 0; i < MAP_W; i++) occupied += map[i];
            r.query = VAL_W'(occupied);
         end
         OP_SET_SECT: r.aisle[idx*SECT_W +: SECT_W] = val;
         OP_SET_TAG: begin
            if (val <= TAG_MAX) r.aisle[idx*SECT_W +: SECT_W] = {val[TAG_W-1:0], map};
         end
         OP_SET_MAP: begin
            if (val <= MAP_MAX) r.aisle[idx*SECT_W +: SECT_W] = {tag, val[MAP_W-1:0]};
         end
         // occupy the lowest empty slots, at most val of them
         OP_FILL: begin
            for (int i = 0; i < MAP_W; i++) begin
               if (!nmap[i] && moved < val) begin
                  nmap[i] = 1'b1;
                  moved++;
               end
            end
            r.aisle[idx*SECT_W +: SECT_W] = {tag, nmap};
         end
         // release the lowest occupied slots, at most val of them
         OP_CLEAR: begin
            for (int i = 0; i < MAP_W; i++) begin
               if (nmap[i] && moved < val) begin
                  nmap[i] = 1'b0;
                  moved++;
               end
            end
            r.aisle[idx*SECT_W +: SECT_W] = {tag, nmap};
         end
         OP_TOGGLE: begin
            if (val < SLOTS) begin
               nmap[val[CNT_W-1:0]] = ~nmap[val[CNT_W-1:0]];
               r.aisle[idx*SECT_W +: SECT_W] = {tag, nmap};
            end
         end
         // right rotation is left rotation by the complement modulo ten
         OP_ROTL, OP_ROTR: begin
            rot = int'(val) % int'(SLOTS);
            if (op == OP_ROTR) rot = (int'(SLOTS) - rot) % int'(SLOTS);
            for (int i = 0; i < rot; i++) nmap = {nmap[MAP_W-2:0], nmap[MAP_W-1]};
            r.aisle[idx*SECT_W +: SECT_W] = {tag, nmap};
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag_fault(input string what, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
      fault_total++;
      if (fault_total <= REPORT_LIMIT)
         $display("MISMATCH at %0t ns: %s expected %h actual %h",
                  $time, what, exp_v, act_v);
   endtask

   // Retire the response first, then queue the prediction for a new request.
   always @(posedge clock) begin
      slot_result_type exp_r;
      if (reset) begin
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               flag_fault("unexpected result, aisle_out", '0, rsp_tdata[WORD_W-1:0]);
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_tdata[WORD_W-1:0] !== exp_r.aisle)
                  flag_fault("aisle_out", exp_r.aisle, rsp_tdata[WORD_W-1:0]);
               if (rsp_tdata[WORD_W +: VAL_W] !== exp_r.query)
                  flag_fault("query_value", WORD_W'(exp_r.query),
                             WORD_W'(rsp_tdata[WORD_W +: VAL_W]));
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(apply_slot_op(req_tuser, req_tdata[WORD_W-1:0],
                                                    req_tdata[WORD_W +: IDX_W],
                                                    req_tdata[WORD_W+IDX_W +: VAL_W]));
      end
      error_count   <= fault_total;
      pending_count <= pending_results.size();
   end

endmodule

// File: tb/testbench.sv
// Top of the packed slot bitmap unit testbench: clock, reset, request stimulus,
// response backpressure, watchdog and verdict.
// Depends on psbu_pkg, packed_slot_bitmap_unit_top and psbu_result_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import psbu_pkg::*;

   localparam int STUCK_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd12;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // aisle_in, sect_sel, operand_value, zero
   logic [OP_W-1:0]       req_tuser  = '0;   // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // aisle_out, query_value

   int error_count;
   int pending_count;
   int send_idle_pct = 0;
   int sink_idle_pct = 0;
   int sink_hold     = 0;
   int stuck_cycles  = 0;

   always #6 clock = ~clock;

   packed_slot_bitmap_unit_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   psbu_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Stall the response side in bursts of random length.
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold  <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!reset && sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
         sink_hold  <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // End the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Present one request, with an optional idle burst ahead of it; hold until accepted.
   task automatic send_slot_op(input logic [OP_W-1:0]   op,
                               input logic [WORD_W-1:0] word,
                               input logic [IDX_W-1:0]  idx,
                               input logic [VAL_W-1:0]  val);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, val, idx, word};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every predicted result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Random requests: mostly legal codes with operands near the limits of each op.
   task automatic run_random(input int count);
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] word;
      logic [IDX_W-1:0]  idx;
      logic [VAL_W-1:0]  val;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 19) == 0)
            op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         else op = OP_W'($urandom_range(OP_GET_SECT, OP_ROTR));
         idx  = IDX_W'($urandom_range(0, NUM_SECT - 1));
         word = {$urandom, $urandom};
         // bias the selected bitmap toward empty and full
         case ($urandom_range(0, 7))
            0: word[idx*SECT_W +: MAP_W] = '0;
            1: word[idx*SECT_W +: MAP_W] = '1;
            default: ;
         endcase
         val = VAL_W'($urandom_range(0, 16'hFFFF));
         case (op)
            OP_SET_TAG: if ($urandom_range(0, 1)) val = VAL_W'($urandom_range(0, TAG_MAX));
            OP_SET_MAP: if ($urandom_range(0, 1)) val = VAL_W'($urandom_range(0, MAP_MAX));
            OP_FILL, OP_CLEAR:
               if ($urandom_range(0, 3) != 0) val = VAL_W'($urandom_range(0, SLOTS + 1));
            OP_TOGGLE:
               if ($urandom_range(0, 3) != 0) val = VAL_W'($urandom_range(0, SLOTS - 1));
            OP_ROTL, OP_ROTR:
               if ($urandom_range(0, 1)) val = VAL_W'($urandom_range(0, 2 * SLOTS));
            default: ;
         endcase
         send_slot_op(op, word, idx, val);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: every code, field extremes and the no-change corners
      send_idle_pct = 20;
      sink_idle_pct = 20;
      send_slot_op(OP_GET_SECT, '1, 2'd3, 16'h0000);
      send_slot_op(OP_GET_TAG, 64'h8421_FC00_0000_7BDE, 2'd2, 16'hFFFF);
      send_slot_op(OP_GET_MAP, 64'h0000_0000_A5A5_0000, 2'd1, 16'h1234);
      send_slot_op(OP_COUNT, '1, 2'd0, 16'h0000);
      send_slot_op(OP_SET_SECT, '0, 2'd3, 16'hFFFF);
      send_slot_op(OP_SET_TAG, 64'h0123_4567_89AB_CDEF, 2'd0, TAG_MAX);
      send_slot_op(OP_SET_TAG, 64'h0123_4567_89AB_CDEF, 2'd1, TAG_MAX + 16'd1);
      send_slot_op(OP_SET_MAP, 64'hFEDC_BA98_7654_3210, 2'd2, MAP_MAX);
      send_slot_op(OP_SET_MAP, 64'hFEDC_BA98_7654_3210, 2'd3, MAP_MAX + 16'd1);
      send_slot_op(OP_FILL, 64'h1234_5A5A_0000_ABCD, 2'd1, 16'd0);
      send_slot_op(OP_FILL, 64'h1234_5A5A_0000_ABCD, 2'd1, 16'd3);
      send_slot_op(OP_FILL, 64'h1234_5A5A_0000_ABCD, 2'd0, 16'hFFFF);
      send_slot_op(OP_CLEAR, 64'hFFFF_0000_0000_0000, 2'd3, 16'd0);
      send_slot_op(OP_CLEAR, 64'h1234_5A5A_03FF_ABCD, 2'd1, VAL_W'(SLOTS) + 16'd1);
      send_slot_op(OP_TOGGLE, 64'h0000_0000_0000_0000, 2'd2, VAL_W'(SLOTS) - 16'd1);
      send_slot_op(OP_TOGGLE, '1, 2'd2, VAL_W'(SLOTS));
      send_slot_op(OP_ROTL, 64'hC3C3_0201_0000_0000, 2'd2, VAL_W'(SLOTS));
      send_slot_op(OP_ROTL, 64'hC3C3_0201_0000_0000, 2'd2, 16'd3);
      send_slot_op(OP_ROTR, 64'h0000_0000_0000_8A01, 2'd0, 16'hFFFF);
      send_slot_op(OP_ROTR, 64'h0000_0000_0000_8A01, 2'd0, 16'd1);
      for (logic [OP_W:0] sp = {1'b0, OP_SPARE_FIRST}; sp <= {1'b0, OP_SPARE_LAST}; sp++)
         send_slot_op(sp[OP_W-1:0], {$urandom, $urandom},
                      IDX_W'($urandom_range(0, NUM_SECT - 1)),
                      VAL_W'($urandom_range(0, 16'hFFFF)));
      wait_drained();

      // random phases: heavy idling, none, moderate, then a quiet tail
      send_idle_pct = 40;
      sink_idle_pct = 40;
      run_random(200);
      send_idle_pct = 0;
      sink_idle_pct = 0;
      run_random(150);
      wait_drained();
      send_idle_pct = 10;
      sink_idle_pct = 15;
      run_random(200);
      send_idle_pct = 0;
      sink_idle_pct = 0;
      run_random(100);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/psbu_pkg.sv
rtl/packed_slot_bitmap_unit_top.sv
tb/psbu_result_checker.sv
tb/testbench.sv
